// File: design/obv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Oriented box vertices package
// Shared widths, CORDIC constants and small helper functions.
// ----------------------------------------------------------------------------
package obv_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF      = 16;
	localparam int TRIG_FRAC_BITS_DEF  = 16;

	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;   // CORDIC x/y width (Q30 plus headroom)
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam int NUM_VERTS = 10;

	typedef logic signed [33:0] cw_t;

	function automatic logic signed [32:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
		endcase
		return $signed({1'b0, t});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// File: design/obv_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Oriented box vertices: sine/cosine pipeline
// Fully pipelined 24-step CORDIC for three angles, one step per stage.
// ----------------------------------------------------------------------------
module obv_cordic #(
	parameter int ANGLE_BITS     = obv_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_FRAC_BITS = obv_pkg::TRIG_FRAC_BITS_DEF,
	parameter int TW             = TRIG_FRAC_BITS + 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [2:0][15:0]     angle,
	output logic                      out_valid,
	output logic signed [2:0][TW-1:0] sin_o,
	output logic signed [2:0][TW-1:0] cos_o
);
	import obv_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic                     v_s1 [N+1];
	logic signed [CW-1:0]     x_s1 [N+1][3];
	logic signed [CW-1:0]     y_s1 [N+1][3];
	logic signed [32:0]       z_s1 [N+1][3];
	logic                     f_s1 [N+1][3];

	// Stage 0: fold angle into the right half-plane.
	always_comb begin
		logic [ANGLE_BITS-1:0] ph;
		logic [31:0]           a;
		v_s1[0] = in_valid;
		for (int k = 0; k < 3; k++) begin
			ph = ANGLE_BITS'({{(ANGLE_BITS){angle[k][15]}}, angle[k]});
			a = {ph, {(32-ANGLE_BITS){1'b0}}};
			f_s1[0][k] = a[31] ^ a[30];
			if (f_s1[0][k]) a[31] = ~a[31];
			z_s1[0][k] = {a[31], a};
			x_s1[0][k] = CORDIC_GAIN_Q30;
			y_s1[0][k] = '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[i+1] <= 1'b0;
			end else if (en) begin
				v_s1[i+1] <= v_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					f_s1[i+1][k] <= f_s1[i][k];
					if (!z_s1[i][k][32]) begin
						x_s1[i+1][k] <= x_s1[i][k] - (y_s1[i][k] >>> i);
						y_s1[i+1][k] <= y_s1[i][k] + (x_s1[i][k] >>> i);
						z_s1[i+1][k] <= z_s1[i][k] - atan_turn(i);
					end else begin
						x_s1[i+1][k] <= x_s1[i][k] + (y_s1[i][k] >>> i);
						y_s1[i+1][k] <= y_s1[i][k] - (x_s1[i][k] >>> i);
						z_s1[i+1][k] <= z_s1[i][k] + atan_turn(i);
					end
				end
			end
		end
	end

	// Round half up to the trig format, then undo the fold.
	always_comb begin
		logic signed [CW-1:0] xr, yr;
		out_valid = v_s1[N];
		for (int k = 0; k < 3; k++) begin
			xr = (x_s1[N][k] + (CW'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
			yr = (y_s1[N][k] + (CW'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
			cos_o[k] = f_s1[N][k] ? -xr[TW-1:0] : xr[TW-1:0];
			sin_o[k] = f_s1[N][k] ? -yr[TW-1:0] : yr[TW-1:0];
		end
	end

endmodule
`default_nettype wire

// File: design/oriented_box_vertices_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Oriented box vertices core
// Rotates the eight half-extent corners of a box by a Z-Y-X Euler rotation.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (tdata from bit 0 up)
// s_axis   in   center_x/y/z, box_length/width/height, yaw/roll/pitch angle
// m_axis   out  tuser vertex_index, tdata vertex_x/y/z, tlast last_vertex
//
// The first vertex of a box is offered after the box has passed the 24-stage
// CORDIC, stages m1 to m3 and the vertex buffer. Ten results leave per box,
// one per cycle while m_axis is ready; a new box can be accepted before earlier
// ones have left. The pipeline advances whenever its last stage is empty or the
// vertex serializer loads. A stall on m_axis freezes the whole pipeline once its
// last stage holds a box; nothing is dropped.
// Reset clears all valid bits and the vertex counter.
// ----------------------------------------------------------------------------
module oriented_box_vertices_core #(
	parameter int COORD_FRAC_BITS = obv_pkg::COORD_FRAC_BITS_DEF,
	parameter int ANGLE_BITS      = obv_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_FRAC_BITS  = obv_pkg::TRIG_FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// center_x[31:0], center_y[63:32], center_z[95:64], box_length[126:96],
	// box_width[157:127], box_height[188:158], yaw[204:189], roll[220:205],
	// pitch[236:221], zero fill
	input  wire logic [239:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// vertex_x[31:0], vertex_y[63:32], vertex_z[95:64]
	output logic [95:0]       m_axis_tdata,
	// vertex_index[3:0]
	output logic [3:0]        m_axis_tuser,
	output logic              m_axis_tlast
);
	import obv_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int PW = 2 * TW;
	localparam int N  = CORDIC_STEPS;

	// The fixed-point format passes through unchanged.
	localparam int CFB_UNUSED = COORD_FRAC_BITS;

	logic en;
	logic accept;
	logic [3:0] cnt_q;
	logic busy_q;
	logic load;
	logic stage_v_out;

	// Payload delay line for center and extents alongside the CORDIC.
	logic [188:0] pay_d [N+4];
	logic cv;
	logic signed [2:0][TW-1:0] s_c, c_c;

	assign load = stage_v_out && (!busy_q || (cnt_q == 4'd9 && m_axis_tready));
	assign en   = !stage_v_out || load;
	assign s_axis_tready = en && (CFB_UNUSED >= 0);
	assign accept = s_axis_tvalid && s_axis_tready;

	obv_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .TW(TW)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(accept),
		.angle({s_axis_tdata[236:221], s_axis_tdata[220:205], s_axis_tdata[204:189]}),
		.out_valid(cv), .sin_o(s_c), .cos_o(c_c));

	assign pay_d[0] = s_axis_tdata[188:0];
	for (genvar i = 0; i < N + 3; i++) begin : g_pay
		always_ff @(posedge clk) if (en) pay_d[i+1] <= pay_d[i];
	end

	// Stage m1: pairwise trig products.
	function automatic logic signed [TW-1:0] tm(input logic signed [TW-1:0] a,
	                                            input logic signed [TW-1:0] b);
		logic signed [PW-1:0] p;
		p = a * b + (PW'(1) <<< (TRIG_FRAC_BITS - 1));
		return TW'(p >>> TRIG_FRAC_BITS);
	endfunction

	logic v_m1, v_m2, v_m3;
	logic signed [TW-1:0] cycp_m1, cysp_m1, sycr_m1, sysr_m1, sycp_m1, sysp_m1;
	logic signed [TW-1:0] cycr_m1, cysr_m1, cpsr_m1, cpcr_m1, sp_m1, sr_m1, cr_m1;
	logic signed [TW:0]   m_m2 [3][3];

	// angle order: 0 yaw, 1 roll, 2 pitch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0; v_m2 <= 1'b0; v_m3 <= 1'b0;
		end else if (en) begin
			v_m1 <= cv; v_m2 <= v_m1; v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycp_m1 <= tm(c_c[0], c_c[2]);
			cysp_m1 <= tm(c_c[0], s_c[2]);
			sycr_m1 <= tm(s_c[0], c_c[1]);
			sysr_m1 <= tm(s_c[0], s_c[1]);
			sycp_m1 <= tm(s_c[0], c_c[2]);
			sysp_m1 <= tm(s_c[0], s_c[2]);
			cycr_m1 <= tm(c_c[0], c_c[1]);
			cysr_m1 <= tm(c_c[0], s_c[1]);
			cpsr_m1 <= tm(c_c[2], s_c[1]);
			cpcr_m1 <= tm(c_c[2], c_c[1]);
			sp_m1 <= s_c[2]; sr_m1 <= s_c[1]; cr_m1 <= c_c[1];
			m_m2[0][0] <= (TW+1)'(cycp_m1);
			m_m2[0][1] <= (TW+1)'(tm(cysp_m1, sr_m1)) - (TW+1)'(sycr_m1);
			m_m2[0][2] <= (TW+1)'(tm(cysp_m1, cr_m1)) + (TW+1)'(sysr_m1);
			m_m2[1][0] <= (TW+1)'(sycp_m1);
			m_m2[1][1] <= (TW+1)'(tm(sysp_m1, sr_m1)) + (TW+1)'(cycr_m1);
			m_m2[1][2] <= (TW+1)'(tm(sysp_m1, cr_m1)) - (TW+1)'(cysr_m1);
			m_m2[2][0] <= -(TW+1)'(sp_m1);
			m_m2[2][1] <= (TW+1)'(cpsr_m1);
			m_m2[2][2] <= (TW+1)'(cpcr_m1);
		end
	end

	// Stage m3: matrix times extents (nine products).
	localparam int QW = TW + 33;
	logic signed [QW-1:0] q_m3 [3][3];
	logic [188:0] pm3;
	assign pm3 = pay_d[N+2];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					q_m3[r][c] <= m_m2[r][c] * $signed({1'b0, pm3[96+31*c +: 31]});
		end
	end

	// Stage m4: signed sums per corner, rounding and saturation.
	logic signed [31:0] vx_s4 [8][3];
	logic signed [31:0] ctr_s4 [3];
	logic signed [31:0] mid_s4 [3];
	logic v_m4;
	logic [188:0] pm4;
	assign pm4 = pay_d[N+3];

	function automatic logic csign(input int i, input int c);
		// 1 means negative sign
		case (c)
			0: return (i % 4 == 2) || (i % 4 == 3);
			1: return (i % 4 == 1) || (i % 4 == 2);
			default: return i < 4;
		endcase
	endfunction

	always_comb begin
		logic signed [QW+1:0] acc;
		logic signed [33:0] t;
		logic signed [32:0] sm;
		for (int i = 0; i < 8; i++)
			for (int r = 0; r < 3; r++) begin
				acc = '0;
				for (int c = 0; c < 3; c++)
					acc = csign(i, c) ? acc - (QW+2)'(q_m3[r][c]) : acc + (QW+2)'(q_m3[r][c]);
				acc = (acc + ((QW+2)'(1) <<< TRIG_FRAC_BITS)) >>> (TRIG_FRAC_BITS + 1);
				t = 34'($signed(pm4[32*r +: 32])) + 34'(acc);
				if (acc > (QW+2)'(34'sh0FFFFFFFF)) t = 34'sh0FFFFFFFF;
				if (acc < -(QW+2)'(34'sh0FFFFFFFF)) t = -34'sh0FFFFFFFF;
				vx_s4[i][r] = sat32(t);
			end
		for (int r = 0; r < 3; r++) begin
			ctr_s4[r] = $signed(pm4[32*r +: 32]);
			sm = 33'(vx_s4[0][r]) + 33'(vx_s4[5][r]);
			mid_s4[r] = sm[32:1];
		end
	end

	logic signed [31:0] buf_q [NUM_VERTS][3];
	assign stage_v_out = v_m3;
	assign v_m4 = v_m3;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 8; i++) buf_q[i] <= vx_s4[i];
			buf_q[8] <= ctr_s4;
			buf_q[9] <= mid_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q && m_axis_tready) begin
			if (cnt_q == 4'd9) busy_q <= 1'b0;
			else cnt_q <= cnt_q + 4'd1;
		end
	end

	assign m_axis_tvalid = busy_q && v_m4 | busy_q;
	assign m_axis_tuser  = cnt_q;
	assign m_axis_tlast  = cnt_q == 4'd9;
	assign m_axis_tdata  = {buf_q[cnt_q][2], buf_q[cnt_q][1], buf_q[cnt_q][0]};

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oriented box vertices testbench
// Drives boxes into the core and predicts the ten vertices of each box with
// its own CORDIC and rotation arithmetic. Every vertex transaction is checked
// field by field against the oldest prediction. The sender works in random
// bursts and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [31:0] cx, cy, cz;
		logic [30:0]        len, wid, hgt;
		logic [15:0]        yaw, roll, pitch;
	} box_t;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] x, y, z;
		logic               last;
	} vertex_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [239:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;
	logic [3:0]   m_axis_tuser;
	logic         m_axis_tlast;

	vertex_t vertex_q[$];
	int      mismatches = 0;
	int      rx_mode;
	logic    hold_off = 1'b0;
	int      rx_cyc;

	longint atan_lut[24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

	oriented_box_vertices_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// Sine and cosine in Q16 of a binary angle, 65536 per turn.
	task automatic trig_of(input logic [15:0] ang, output longint s, output longint c);
		logic [31:0] a;
		logic        flip;
		longint      x, y, z, nx;
		a = {ang, 16'h0000};
		flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (flip)
			a = a ^ 32'h80000000;
		x = 652032874;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_lut[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_lut[i];
			end
			x = nx;
		end
		x = (x + (64'sd1 <<< 13)) >>> 14;
		y = (y + (64'sd1 <<< 13)) >>> 14;
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endtask

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	task automatic predict_vertices(input box_t b);
		longint  sy, cy, sr, cr, sp, cp, acc;
		longint  m[3][3];
		longint  ctr[3];
		longint  ext[3];
		longint  v[8][3];
		int      sgn[3];
		vertex_t e;
		trig_of(b.yaw, sy, cy);
		trig_of(b.roll, sr, cr);
		trig_of(b.pitch, sp, cp);
		ctr[0] = longint'(b.cx);
		ctr[1] = longint'(b.cy);
		ctr[2] = longint'(b.cz);
		ext[0] = longint'(b.len);
		ext[1] = longint'(b.wid);
		ext[2] = longint'(b.hgt);
		m[0][0] = qmul(cy, cp);
		m[0][1] = qmul(qmul(cy, sp), sr) - qmul(sy, cr);
		m[0][2] = qmul(qmul(cy, sp), cr) + qmul(sy, sr);
		m[1][0] = qmul(sy, cp);
		m[1][1] = qmul(qmul(sy, sp), sr) + qmul(cy, cr);
		m[1][2] = qmul(qmul(sy, sp), cr) - qmul(cy, sr);
		m[2][0] = -sp;
		m[2][1] = qmul(cp, sr);
		m[2][2] = qmul(cp, cr);
		for (int i = 0; i < 8; i++) begin
			// Corner order: front/back from bit 1, left/right from bits 1 and 0, then top.
			sgn[0] = (i == 0 || i == 1 || i == 4 || i == 5) ? 1 : -1;
			sgn[1] = (i == 0 || i == 3 || i == 4 || i == 7) ? 1 : -1;
			sgn[2] = (i < 4) ? -1 : 1;
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int c = 0; c < 3; c++)
					acc += m[r][c] * (sgn[c] * ext[c]);
				acc = (acc + 65536) >>> 17;
				v[i][r] = clip32(ctr[r] + acc);
			end
			e.idx = 4'(i);
			e.x = 32'(v[i][0]);
			e.y = 32'(v[i][1]);
			e.z = 32'(v[i][2]);
			e.last = 1'b0;
			vertex_q.push_back(e);
		end
		e.idx = 4'd8;
		e.x = b.cx;
		e.y = b.cy;
		e.z = b.cz;
		vertex_q.push_back(e);
		e.idx = 4'd9;
		e.x = 32'((v[0][0] + v[5][0]) >>> 1);
		e.y = 32'((v[0][1] + v[5][1]) >>> 1);
		e.z = 32'((v[0][2] + v[5][2]) >>> 1);
		e.last = 1'b1;
		vertex_q.push_back(e);
	endtask

	// Called at a rising edge; returns at the edge where the box was taken.
	task automatic send_box(input box_t b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, b.pitch, b.roll, b.yaw, b.hgt, b.wid, b.len,
			b.cz, b.cy, b.cx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_vertices(b);
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 4000) - 2000;
			1: return $urandom() >> $urandom_range(8, 20);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] rand_extent();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 1000));
			1: return 31'($urandom() >> $urandom_range(9, 24));
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic box_t rand_box();
		box_t b;
		b.cx = rand_coord();
		b.cy = rand_coord();
		b.cz = rand_coord();
		b.len = rand_extent();
		b.wid = rand_extent();
		b.hgt = rand_extent();
		b.yaw = 16'($urandom());
		b.roll = 16'($urandom());
		b.pitch = 16'($urandom());
		return b;
	endfunction

	function automatic box_t make_box(input logic signed [31:0] c, input logic [30:0] ex,
			input logic [15:0] y, input logic [15:0] r, input logic [15:0] p);
		box_t b;
		b.cx = c;
		b.cy = -c;
		b.cz = c ^ 32'h5A5A5A5A;
		b.len = ex;
		b.wid = ex >> 1;
		b.hgt = ~ex;
		b.yaw = y;
		b.roll = r;
		b.pitch = p;
		return b;
	endfunction

	task automatic run_bursts(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_box(rand_box());
				left--;
			end
			idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
		end
		idle_gap(1);
	endtask

	task automatic test_directed();
		box_t dir_q[$];
		dir_q.push_back(make_box(32'h0, 31'h0, 16'h0000, 16'h0000, 16'h0000));
		dir_q.push_back(make_box(32'h00010000, 31'h00020000, 16'h0000, 16'h0000, 16'h0000));
		dir_q.push_back(make_box(32'h7FFFFFFF, 31'h7FFFFFFF, 16'h0000, 16'h0000, 16'h0000));
		dir_q.push_back(make_box(32'h80000000, 31'h7FFFFFFF, 16'h4000, 16'h0000, 16'h0000));
		dir_q.push_back(make_box(32'h80000000, 31'h7FFFFFFF, 16'h8000, 16'h8000, 16'h8000));
		dir_q.push_back(make_box(32'h7FFFFFFF, 31'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		dir_q.push_back(make_box(32'h12345678, 31'h00300000, 16'h4000, 16'hC000, 16'h4000));
		dir_q.push_back(make_box(32'hFFFFFFFF, 31'h00300000, 16'hC000, 16'h4000, 16'hC000));
		dir_q.push_back(make_box(32'h00000001, 31'h00000001, 16'h3FFF, 16'h4001, 16'hBFFF));
		dir_q.push_back(make_box(32'h00500000, 31'h00000003, 16'hC001, 16'h2000, 16'hE000));
		dir_q.push_back(make_box(32'hFFF00000, 31'h000A0000, 16'h2000, 16'h2000, 16'h2000));
		dir_q.push_back(make_box(32'h7FFF0000, 31'h40000000, 16'h6000, 16'hA000, 16'h1234));
		dir_q.push_back(make_box(32'h80010000, 31'h40000000, 16'hA000, 16'h6000, 16'hFEDC));
		dir_q.push_back(make_box(32'h00000000, 31'h7FFFFFFF, 16'h0001, 16'hFFFF, 16'h8001));
		dir_q.push_back(make_box(32'hA5A5A5A5, 31'h55555555, 16'hAAAA, 16'h5555, 16'hFFFF));
		// Mixed extents so that each axis alone reaches its maximum.
		dir_q.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 31'h7FFFFFFF, 31'h0,
			31'h0, 16'h0000, 16'h0000, 16'h0000});
		dir_q.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h0, 31'h7FFFFFFF,
			31'h0, 16'h8000, 16'h0000, 16'h0000});
		dir_q.push_back('{32'h00000000, 32'h80000000, 32'h80000000, 31'h0, 31'h0,
			31'h7FFFFFFF, 16'h0000, 16'h8000, 16'h4000});
		rx_mode = 0;
		foreach (dir_q[i]) begin
			send_box(dir_q[i]);
			idle_gap(i % 3);
		end
		idle_gap(1);
	endtask

	task automatic test_random();
		rx_mode = 1;
		run_bursts(160);
		rx_mode = 0;
		run_bursts(160);
		rx_mode = 2;
		run_bursts(160);
	endtask

	// The receiver holds tready low through a hold-off while boxes keep coming.
	task automatic test_backpressure();
		rx_mode = 1;
		fork
			begin
				hold_off <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		for (int k = 0; k < 25; k++)
			send_box(rand_box());
		idle_gap(1);
	endtask

	// Result side: checks each vertex transaction and drives tready.
	always @(posedge clk) begin
		vertex_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_cyc <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				if (vertex_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex %0d x=%h y=%h z=%h", m_axis_tuser,
							m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]);
				end else begin
					e = vertex_q.pop_front();
					if (m_axis_tuser !== e.idx || m_axis_tdata[31:0] !== e.x ||
							m_axis_tdata[63:32] !== e.y || m_axis_tdata[95:64] !== e.z ||
							m_axis_tlast !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("vertex mismatch: exp idx=%0d x=%h y=%h z=%h last=%b, got idx=%0d x=%h y=%h z=%h last=%b",
								e.idx, e.x, e.y, e.z, e.last, m_axis_tuser, m_axis_tdata[31:0],
								m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tlast);
					end
				end
			end
			if (hold_off)
				m_axis_tready <= 1'b0;
			else if (rx_mode == 0)
				m_axis_tready <= 1'b1;
			else if (rx_mode == 1)
				m_axis_tready <= ($urandom_range(0, 99) < 60);
			else
				m_axis_tready <= ((rx_cyc % 11) > 3);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		rx_mode = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		rx_mode = 1;
		while (vertex_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
